/* src/tiad_pkg.sv */
// Shared types and constants for the trade iceberg and absorption detector.
`timescale 1ns / 1ps

package tiad_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_PRICE_BITS  = 24;

   localparam int CNT_W    = 8;
   localparam int EV_PRICE_W  = 24;
   localparam int EV_AMOUNT_W = 32;
   localparam int SIZE_W   = 20;

   localparam logic [CNT_W-1:0] COUNT_MAX       = 8'd255;
   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;
   localparam int               RUN_WINDOW      = 49;

   // aggressor codes
   localparam logic [1:0] SIDE_BID = 2'd0;
   localparam logic [1:0] SIDE_ASK = 2'd1;

   // event kinds
   localparam logic [1:0] KIND_ICE_BID = 2'd0;
   localparam logic [1:0] KIND_ICE_ASK = 2'd1;
   localparam logic [1:0] KIND_ABS_BID = 2'd2;
   localparam logic [1:0] KIND_ABS_ASK = 2'd3;

   // register map (word index), byte address is 4 * index
   localparam int          CSR_ADDR_W       = 3;
   localparam logic        REG_THRESHOLD    = 1'b0;

   typedef struct packed {
      logic [1:0]             kind;
      logic [EV_PRICE_W-1:0]  price;
      logic [EV_AMOUNT_W-1:0] amount;
      logic                   last;
   } event_type;

endpackage

/* src/trade_iceberg_absorption_detector.sv */
// Top level: per-side refill tables and absorption runs, emitting event beats.
`timescale 1ns / 1ps

// Takes one trade beat per cycle while req_tready is high and answers with zero, one or
// two event beats. A trade goes through two register stages: the input register, which
// also launches the read of the side's refill table, and the result register, written in
// the same cycle as the table entry and the absorption run are updated. Events leave one
// beat per cycle while rsp_tready is high, so when a trade raises both an iceberg and an
// absorption event, the next trade waits in the input register until the first beat is
// taken. After reset the refill tables are cleared one entry a cycle, all 2*TABLE_DEPTH
// entries (512 at the default depth), during which req_tready is low.
// TABLE_DEPTH must be a power of two; the table is indexed by the low price bits.
module trade_iceberg_absorption_detector #(
   parameter int TABLE_DEPTH = tiad_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PRICE_BITS  = tiad_pkg::DEFAULT_PRICE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // trade in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // price_cents[23:0], trade_size[43:24], zero pad
   input  logic [1:0]  req_tuser,  // aggressor[1:0]
   // events out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // event_price[23:0], event_amount[55:24]
   output logic [1:0]  rsp_tuser,  // event_kind[1:0]
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [tiad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int ADDR_W = IDX_W + 1;
   localparam int CNT_W  = tiad_pkg::CNT_W;
   localparam int ENT_W  = 1 + PRICE_BITS + CNT_W;
   localparam int AMT_W  = tiad_pkg::EV_AMOUNT_W;

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] thr_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == tiad_pkg::REG_THRESHOLD);
   assign csr_prdata = (csr_paddr[2] == tiad_pkg::REG_THRESHOLD) ?
                       {{(32-CNT_W){1'b0}}, thr_ff} : 32'd0;

   // ---------------- input decode ----------------
   logic [PRICE_BITS-1:0] req_key;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  req_accept;

   assign req_key    = PRICE_BITS'(req_tdata[23:0]);
   assign rd_addr    = {req_tuser[0], req_key[IDX_W-1:0]};
   assign req_accept = req_tvalid && req_tready;

   // ---------------- pipeline state ----------------
   logic                  s1_valid_ff;
   logic [PRICE_BITS-1:0] s1_price_ff;
   logic [tiad_pkg::SIZE_W-1:0] s1_size_ff;
   logic [1:0]            s1_side_ff;

   logic [ENT_W-1:0]      table_mem [2*TABLE_DEPTH];
   logic [ENT_W-1:0]      mem_rd_ff;
   logic                  fwd_ff;
   logic [ENT_W-1:0]      fwd_data_ff;

   logic                  clr_busy_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;

   logic [PRICE_BITS-1:0] run_price_ff   [2];
   logic [AMT_W-1:0]      run_volume_ff  [2];
   logic [CNT_W-1:0]      run_refills_ff [2];

   tiad_pkg::event_type   slot0_ff, slot1_ff;
   logic [1:0]            n_ff;

   // ---------------- result stage logic ----------------
   logic                  can_go, commit, known, sd, wr_en, mem_we;
   logic [ADDR_W-1:0]     s1_addr, mem_waddr;
   logic [ENT_W-1:0]      ent, wr_data, mem_wdata;
   logic                  ent_valid, hit, ice, absorb, pop;
   logic [PRICE_BITS-1:0] ent_price, cur_price, diff;
   logic [CNT_W-1:0]      ent_count, new_count, cur_refills, run_refills_in;
   logic [AMT_W-1:0]      cur_volume, run_volume_in;
   logic [AMT_W:0]        vol_sum;
   logic [PRICE_BITS-1:0] run_price_in;
   logic                  near;
   tiad_pkg::event_type   ice_ev, abs_ev, first_ev;

   assign pop    = rsp_tvalid && rsp_tready;
   assign can_go = (n_ff == 2'd0) || ((n_ff == 2'd1) && rsp_tready);
   assign commit = s1_valid_ff && can_go;
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || can_go);

   assign known  = (s1_side_ff == tiad_pkg::SIDE_BID) || (s1_side_ff == tiad_pkg::SIDE_ASK);
   assign sd     = s1_side_ff[0];
   assign s1_addr = {sd, s1_price_ff[IDX_W-1:0]};
   assign wr_en  = commit && known;

   // entry written in the same cycle as this read is taken from the bypass
   assign ent       = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign ent_valid = ent[ENT_W-1];
   assign ent_price = ent[CNT_W +: PRICE_BITS];
   assign ent_count = ent[CNT_W-1:0];

   assign hit       = ent_valid && (ent_price == s1_price_ff);
   assign new_count = !hit ? CNT_W'(1) :
                      (ent_count == tiad_pkg::COUNT_MAX) ? ent_count : ent_count + 1'b1;
   assign wr_data   = {1'b1, s1_price_ff, new_count};
   assign ice       = known && hit && (new_count >= thr_ff);

   assign cur_price   = run_price_ff[sd];
   assign cur_volume  = run_volume_ff[sd];
   assign cur_refills = run_refills_ff[sd];
   assign diff = (s1_price_ff >= cur_price) ? s1_price_ff - cur_price
                                            : cur_price - s1_price_ff;
   assign near = diff <= PRICE_BITS'(tiad_pkg::RUN_WINDOW);
   assign vol_sum = {1'b0, cur_volume} + (AMT_W+1)'(s1_size_ff);

   always_comb begin
      if (near) begin
         run_price_in   = cur_price;
         run_volume_in  = vol_sum[AMT_W] ? {AMT_W{1'b1}} : vol_sum[AMT_W-1:0];
         run_refills_in = (cur_refills == tiad_pkg::COUNT_MAX) ? cur_refills
                                                               : cur_refills + 1'b1;
      end else begin
         run_price_in   = s1_price_ff;
         run_volume_in  = AMT_W'(s1_size_ff);
         run_refills_in = CNT_W'(1);
      end
   end

   assign absorb = known && (run_refills_in >= thr_ff);

   always_comb begin
      ice_ev.kind   = sd ? tiad_pkg::KIND_ICE_ASK : tiad_pkg::KIND_ICE_BID;
      ice_ev.price  = tiad_pkg::EV_PRICE_W'(s1_price_ff);
      ice_ev.amount = AMT_W'(s1_size_ff);
      ice_ev.last   = !absorb;
      abs_ev.kind   = sd ? tiad_pkg::KIND_ABS_ASK : tiad_pkg::KIND_ABS_BID;
      abs_ev.price  = tiad_pkg::EV_PRICE_W'(s1_price_ff);
      abs_ev.amount = run_volume_in;
      abs_ev.last   = 1'b1;
      first_ev      = ice ? ice_ev : abs_ev;
   end

   // clearing pass owns the write port until it ends
   assign mem_we    = clr_busy_ff || wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_addr;
   assign mem_wdata = clr_busy_ff ? {ENT_W{1'b0}} : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rd_ff   <= table_mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= tiad_pkg::THRESHOLD_RESET;
         s1_valid_ff    <= 1'b0;
         fwd_ff         <= 1'b0;
         clr_busy_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         n_ff           <= 2'd0;
         for (int i = 0; i < 2; i++) begin
            run_price_ff[i]   <= '0;
            run_volume_ff[i]  <= '0;
            run_refills_ff[i] <= '0;
         end
      end else begin
         if (csr_wr) begin
            thr_ff <= csr_pwdata[CNT_W-1:0];
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= wr_en && (rd_addr == s1_addr);
         end else if (commit) begin
            s1_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            run_price_ff[sd]   <= run_price_in;
            run_volume_ff[sd]  <= run_volume_in;
            run_refills_ff[sd] <= run_refills_in;
         end
         if (commit) begin
            n_ff <= 2'(ice) + 2'(absorb);
         end else if (pop) begin
            n_ff <= n_ff - 2'd1;
         end
      end
   end

   // result slots: payload only
   always_ff @(posedge clock) begin
      if (commit) begin
         slot0_ff <= first_ev;
         slot1_ff <= abs_ev;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
      if (req_accept) begin
         s1_price_ff <= req_key;
         s1_size_ff  <= req_tdata[43:24];
         s1_side_ff  <= req_tuser;
      end
   end

   assign rsp_tvalid = (n_ff != 2'd0);
   assign rsp_tdata  = {slot0_ff.amount, slot0_ff.price};
   assign rsp_tuser  = slot0_ff.kind;
   assign rsp_tlast  = slot0_ff.last;

endmodule

/* src/tiad_checker.sv */
// Port-level checks for the detector and their binding to the top level.
`timescale 1ns / 1ps

module tiad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [tiad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == tiad_pkg::REG_THRESHOLD);

   // a stalled event beat keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("event beat changed while stalled");

   // table clearing runs right after reset, no trade taken then
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("trade accepted before table clear");

   // only an iceberg event can be followed by another beat of the same trade
   a_first_is_iceberg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
      (rsp_tuser == tiad_pkg::KIND_ICE_BID) || (rsp_tuser == tiad_pkg::KIND_ICE_ASK))
      else $error("non-final beat is not an iceberg event");

   // threshold reads back what was written
   a_thr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (csr_paddr[2] != tiad_pkg::REG_THRESHOLD) ||
      (csr_prdata[7:0] == $past(csr_pwdata[7:0])))
      else $error("threshold readback mismatch");

endmodule

bind trade_iceberg_absorption_detector tiad_checker u_tiad_checker (.*);
